[rtl/core/wsdf_pkg.sv]
// websocket deframer package: result kinds, parser phases and the queue word
// no dependencies; imported by every module of the deframer
package wsdf_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
   localparam logic [15:0] MAX_PAYLOAD_RESET   = 16'd4096;

   localparam logic [3:0] OPC_MASK   = 4'hF;
   localparam logic [3:0] OPC_CLOSE  = 4'h8;
   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;
   localparam logic [2:0] EXT16_LEFT = 3'd1;
   localparam logic [2:0] EXT64_LEFT = 3'd7;
   localparam logic [2:0] KEY_LEFT   = 3'd3;

   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_EMPTY    = 2'd1,
      KIND_OVERSIZE = 2'd2,
      KIND_UNMASKED = 2'd3
   } kind_type;

   typedef enum logic [5:0] {
      PH_HDR0    = 6'b000001,
      PH_HDR1    = 6'b000010,
      PH_LEN     = 6'b000100,
      PH_MASK    = 6'b001000,
      PH_PAYLOAD = 6'b010000,
      PH_HALT    = 6'b100000
   } phase_type;

   // one classified byte on its way from the parser to the output stage
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  raw;
      logic [7:0]  key_byte;
      logic [3:0]  opcode;
      logic        last;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic has_item;
   } qstat_type;

endpackage

[rtl/core/wsdf_if.sv]
// channel interfaces of the websocket deframer: input bytes, results, csr writes
// depends on nothing; one valid/ready pair per channel
interface wsdf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface wsdf_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data;
   logic [3:0] opcode;
   logic       last_of_frame;
   modport source (output valid, output kind, output data, output opcode,
                   output last_of_frame, input ready);
   modport sink   (input valid, input kind, input data, input opcode,
                   input last_of_frame, output ready);
endinterface

interface wsdf_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] max_payload;
   modport source (output valid, output max_payload, input ready);
   modport sink   (input valid, input max_payload, output ready);
endinterface

[rtl/core/wsdf_front.sv]
// header parser: walks the frame header, checks length and mask, classifies bytes
// depends on wsdf_pkg and the channel interfaces in wsdf_if.sv
module wsdf_front
   import wsdf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   wsdf_req_if.sink    req_bus,
   wsdf_csr_if.sink    csr_bus,
   input  qstat_type   q_stat,
   output logic        push,
   output cmd_type     push_cmd
);

   phase_type   phase_ff,   phase_in;
   logic [3:0]  opcode_ff,  opcode_in;
   logic        mask_ff,    mask_in;
   logic [15:0] len_ff,     len_in;
   logic        big_ff,     big_in;
   logic [2:0]  left_ff,    left_in;
   logic [31:0] key_ff,     key_in;
   logic [15:0] pos_ff,     pos_in;
   logic [15:0] max_ff;

   logic        accept;
   logic [7:0]  b;
   logic [15:0] len_chk;
   logic        big_chk;
   logic        mask_chk;
   logic        do_check;
   logic [15:0] pos_next;
   logic [7:0]  key_sel;

   assign req_bus.ready = !q_stat.full;
   assign csr_bus.ready = 1'b1;
   assign accept        = req_bus.valid && req_bus.ready;
   assign b             = req_bus.in_byte;
   assign pos_next      = pos_ff + 16'd1;

   always_comb begin
      unique case (pos_ff[1:0])
         2'd0: key_sel = key_ff[31:24];
         2'd1: key_sel = key_ff[23:16];
         2'd2: key_sel = key_ff[15:8];
         default: key_sel = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      opcode_in = opcode_ff;
      mask_in   = mask_ff;
      len_in    = len_ff;
      big_in    = big_ff;
      left_in   = left_ff;
      key_in    = key_ff;
      pos_in    = pos_ff;
      push      = 1'b0;
      push_cmd  = '{kind: KIND_PAYLOAD, raw: 8'd0, key_byte: 8'd0,
                    opcode: opcode_ff, last: 1'b0};
      len_chk   = len_ff;
      big_chk   = big_ff;
      mask_chk  = mask_ff;
      do_check  = 1'b0;

      if (accept) begin
         unique case (phase_ff)
            PH_HDR0: begin
               opcode_in = b[3:0] & OPC_MASK;
               phase_in  = PH_HDR1;
            end
            PH_HDR1: begin
               mask_in  = b[7];
               mask_chk = b[7];
               big_in   = 1'b0;
               big_chk  = 1'b0;
               if (b[6:0] == LEN7_EXT16) begin
                  len_in   = 16'd0;
                  left_in  = EXT16_LEFT;
                  phase_in = PH_LEN;
               end else if (b[6:0] == LEN7_EXT64) begin
                  len_in   = 16'd0;
                  left_in  = EXT64_LEFT;
                  phase_in = PH_LEN;
               end else begin
                  len_in   = {9'd0, b[6:0]};
                  len_chk  = {9'd0, b[6:0]};
                  do_check = 1'b1;
               end
            end
            PH_LEN: begin
               // anything shifted past bit 15 can never pass the length check
               len_in  = {len_ff[7:0], b};
               big_in  = big_ff || (len_ff[15:8] != 8'd0);
               len_chk = len_in;
               big_chk = big_in;
               if (left_ff == 3'd0) begin
                  do_check = 1'b1;
               end else begin
                  left_in = left_ff - 3'd1;
               end
            end
            PH_MASK: begin
               key_in = {key_ff[23:0], b};
               if (left_ff != 3'd0) begin
                  left_in = left_ff - 3'd1;
               end else begin
                  pos_in = 16'd0;
                  if (len_ff == 16'd0) begin
                     push          = 1'b1;
                     push_cmd.kind = KIND_EMPTY;
                     push_cmd.last = 1'b1;
                     phase_in      = (opcode_ff == OPC_CLOSE) ? PH_HALT : PH_HDR0;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               pos_in            = pos_next;
               push              = 1'b1;
               push_cmd.raw      = b;
               push_cmd.key_byte = key_sel;
               if (pos_next == len_ff || pos_next == 16'd0) begin
                  push_cmd.last = 1'b1;
                  phase_in      = (opcode_ff == OPC_CLOSE) ? PH_HALT : PH_HDR0;
               end
            end
            PH_HALT: begin
               phase_in = PH_HALT;
            end
            default: begin
               phase_in = PH_HALT;
            end
         endcase

         // oversize wins over a missing mask bit
         if (do_check) begin
            if (big_chk || (len_chk > max_ff)) begin
               push          = 1'b1;
               push_cmd.kind = KIND_OVERSIZE;
               phase_in      = PH_HALT;
            end else if (!mask_chk) begin
               push          = 1'b1;
               push_cmd.kind = KIND_UNMASKED;
               phase_in      = PH_HALT;
            end else begin
               phase_in = PH_MASK;
               left_in  = KEY_LEFT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         opcode_ff <= 4'd0;
         mask_ff   <= 1'b0;
         len_ff    <= 16'd0;
         big_ff    <= 1'b0;
         left_ff   <= 3'd0;
         key_ff    <= 32'd0;
         pos_ff    <= 16'd0;
         max_ff    <= MAX_PAYLOAD_RESET;
      end else begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         mask_ff   <= mask_in;
         len_ff    <= len_in;
         big_ff    <= big_in;
         left_ff   <= left_in;
         key_ff    <= key_in;
         pos_ff    <= pos_in;
         if (csr_bus.valid && csr_bus.ready) begin
            max_ff <= csr_bus.max_payload;
         end
      end
   end

endmodule

[rtl/core/wsdf_queue.sv]
// short fifo of classified bytes between the parser and the output stage
// depends on wsdf_pkg for the queue word and status types
module wsdf_queue
   import wsdf_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  cmd_type   push_cmd,
   input  logic      pop,
   output cmd_type   head,
   output qstat_type q_stat
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   cmd_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in;
   logic [PW-1:0]   rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   assign q_stat.full     = (cnt_ff == CW'(DEPTH));
   assign q_stat.has_item = (cnt_ff != '0);
   assign head            = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

[rtl/core/wsdf_back.sv]
// output stage: unmasks the queued byte and holds the result word for the sink
// depends on wsdf_pkg and the result interface in wsdf_if.sv
module wsdf_back
   import wsdf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    head,
   input  qstat_type  q_stat,
   output logic       pop,
   wsdf_rsp_if.source rsp_bus
);

   logic       valid_ff;
   kind_type   kind_ff;
   logic [7:0] data_ff;
   logic [3:0] opcode_ff;
   logic       last_ff;

   assign pop = q_stat.has_item && (!valid_ff || rsp_bus.ready);

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.kind          = kind_ff;
   assign rsp_bus.data          = data_ff;
   assign rsp_bus.opcode        = opcode_ff;
   assign rsp_bus.last_of_frame = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         valid_ff <= 1'b0;
      end
   end

   // raw and key byte are zero for everything but payload words
   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff   <= head.kind;
         data_ff   <= head.raw ^ head.key_byte;
         opcode_ff <= head.opcode;
         last_ff   <= head.last;
      end
   end

endmodule

[rtl/core/websocket_frame_deframer.sv]
// top level of the websocket client frame deframer with payload unmasking
// depends on wsdf_pkg, wsdf_if.sv, wsdf_front, wsdf_queue and wsdf_back
//
//   channel   dir  handshake           word
//   req_bus   in   valid/ready         in_byte: one stream byte
//   rsp_bus   out  valid/ready         kind, data, opcode, last_of_frame
//   csr_bus   in   valid/ready         max_payload (ready is always high)
//
// one byte a cycle while the queue is not full; a result goes from its taken byte
// through the queue write and then the output register on its way to rsp_bus
// reset is synchronous; it restores max_payload to 4096 and awaits a header byte
// a stalled sink fills the QUEUE_DEPTH word queue, then req_bus.ready drops
// once halted (error or close) bytes are still taken and dropped until reset
module websocket_frame_deframer
   import wsdf_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  logic       clock,
   input  logic       reset,
   wsdf_req_if.sink   req_bus,
   wsdf_rsp_if.source rsp_bus,
   wsdf_csr_if.sink   csr_bus
);

   qstat_type q_stat;
   logic      push;
   logic      pop;
   cmd_type   push_cmd;
   cmd_type   head;

   wsdf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .csr_bus  (csr_bus),
      .q_stat   (q_stat),
      .push     (push),
      .push_cmd (push_cmd)
   );

   wsdf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .q_stat   (q_stat)
   );

   wsdf_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .q_stat  (q_stat),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full)
      else $error("queue written while full");

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_stat.has_item)
      else $error("queue read while empty");

   a_pop_loads_output: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_bus.valid && rsp_bus.opcode == $past(head.opcode))
      else $error("queued word not loaded into output register");

   a_non_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.kind != KIND_PAYLOAD |->
         rsp_bus.data == 8'd0 && (rsp_bus.kind != KIND_EMPTY || rsp_bus.last_of_frame))
      else $error("non-payload result carries data or lacks last mark");

endmodule

[tb/tb_websocket_frame_deframer.sv]
// testbench for websocket_frame_deframer: a directed table, random masked frames over several
// max_payload settings, then one halting case; every result word is checked against a predictor
// depends on wsdf_pkg and the channel interfaces of wsdf_if.sv
module tb_websocket_frame_deframer;
   import wsdf_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_OCTETS   = 95;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TAIL_CYCLES    = 20;
   localparam int GAP_PCT [4]    = '{0, 50, 0, 9};
   localparam int STALL_PCT [4]  = '{0, 0, 50, 9};

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic [3:0] opcode;
      logic       last;
   } deframed_type;

   typedef struct packed {
      logic [7:0]   octet;
      logic         typed;
      deframed_type want;
   } directed_row_type;

   localparam deframed_type NO_WORD = '{KIND_PAYLOAD, 8'h00, 4'h0, 1'b0};
   localparam int DIRECTED_ROWS = 26;

   // ping with a five byte payload, so the key wraps; then a 64-bit length of one
   // under an all-ones key
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{8'h89, 1'b0, NO_WORD}, '{8'h85, 1'b0, NO_WORD},
      '{8'h12, 1'b0, NO_WORD}, '{8'h34, 1'b0, NO_WORD},
      '{8'h56, 1'b0, NO_WORD}, '{8'h78, 1'b0, NO_WORD},
      '{8'h00, 1'b0, NO_WORD}, '{8'hFF, 1'b0, NO_WORD},
      '{8'h00, 1'b0, NO_WORD}, '{8'hFF, 1'b0, NO_WORD},
      '{8'h5A, 1'b0, NO_WORD},
      '{8'h0F, 1'b0, NO_WORD}, '{8'hFF, 1'b0, NO_WORD},
      '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
      '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
      '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
      '{8'h00, 1'b0, NO_WORD}, '{8'h01, 1'b0, NO_WORD},
      '{8'hFF, 1'b0, NO_WORD}, '{8'hFF, 1'b0, NO_WORD},
      '{8'hFF, 1'b0, NO_WORD}, '{8'hFF, 1'b0, NO_WORD},
      '{8'h00, 1'b1, '{KIND_PAYLOAD, 8'hFF, 4'hF, 1'b1}}
   };

   logic clock = 1'b0;
   logic reset;

   wsdf_req_if req_bus ();
   wsdf_rsp_if rsp_bus ();
   wsdf_csr_if csr_bus ();

   websocket_frame_deframer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // predictor state
   phase_type   p_phase;
   logic [3:0]  p_opcode;
   logic        p_masked;
   logic [63:0] p_length;
   logic [2:0]  p_left;
   logic [31:0] p_key;
   logic [15:0] p_pos;
   logic [15:0] p_max;

   deframed_type pending_words [$];
   int fail_count    = 0;
   int words_checked = 0;
   int octets_taken  = 0;
   int idle_cycles   = 0;
   int gap_pct       = 0;
   int stall_pct     = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic report_mismatch(input string what, input logic [7:0] seen,
                                  input logic [7:0] wanted);
      fail_count++;
      if (fail_count <= 50) begin
         $display("mismatch: %s, got 0x%0h, expected 0x%0h (word %0d)",
                  what, seen, wanted, words_checked);
      end
   endtask

   function automatic bit judge_length(output deframed_type res);
      res = NO_WORD;
      // oversize wins over a missing mask
      if (p_length > {48'd0, p_max}) begin
         p_phase = PH_HALT;
         res = '{KIND_OVERSIZE, 8'h00, p_opcode, 1'b0};
         return 1'b1;
      end
      if (!p_masked) begin
         p_phase = PH_HALT;
         res = '{KIND_UNMASKED, 8'h00, p_opcode, 1'b0};
         return 1'b1;
      end
      p_phase = PH_MASK;
      p_left  = KEY_LEFT;
      return 1'b0;
   endfunction

   function automatic void close_out_frame();
      p_phase = (p_opcode == OPC_CLOSE) ? PH_HALT : PH_HDR0;
   endfunction

   function automatic bit deframe_byte(input logic [7:0] b, output deframed_type res);
      logic [6:0] len7;
      logic [7:0] key_byte;
      res = NO_WORD;
      deframe_byte = 1'b0;
      case (p_phase)
         PH_HDR0: begin
            p_opcode = b[3:0];
            p_phase  = PH_HDR1;
         end
         PH_HDR1: begin
            p_masked = b[7];
            len7     = b[6:0];
            p_length = '0;
            if (len7 == LEN7_EXT16) begin
               p_left  = EXT16_LEFT;
               p_phase = PH_LEN;
            end else if (len7 == LEN7_EXT64) begin
               p_left  = EXT64_LEFT;
               p_phase = PH_LEN;
            end else begin
               p_length = {57'd0, len7};
               deframe_byte = judge_length(res);
            end
         end
         PH_LEN: begin
            p_length = {p_length[55:0], b};
            if (p_left == 3'd0) deframe_byte = judge_length(res);
            else p_left = p_left - 3'd1;
         end
         PH_MASK: begin
            p_key = {p_key[23:0], b};
            if (p_left != 3'd0) begin
               p_left = p_left - 3'd1;
            end else begin
               p_pos = '0;
               if (p_length == 64'd0) begin
                  close_out_frame();
                  res = '{KIND_EMPTY, 8'h00, p_opcode, 1'b1};
                  deframe_byte = 1'b1;
               end else begin
                  p_phase = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            // first key byte sits in the high byte of the key
            key_byte = 8'(p_key >> (5'd24 - {p_pos[1:0], 3'b000}));
            p_pos = p_pos + 16'd1;
            if ({48'd0, p_pos} == p_length || p_pos == 16'd0) begin
               close_out_frame();
               res = '{KIND_PAYLOAD, b ^ key_byte, p_opcode, 1'b1};
            end else begin
               res = '{KIND_PAYLOAD, b ^ key_byte, p_opcode, 1'b0};
            end
            deframe_byte = 1'b1;
         end
         default: p_phase = PH_HALT;
      endcase
   endfunction

   always @(posedge clock) begin : result_check
      deframed_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_words.size() == 0) begin
            report_mismatch("result word with nothing expected", rsp_bus.data, 8'h00);
         end else begin
            want = pending_words.pop_front();
            if (rsp_bus.kind !== want.kind)
               report_mismatch("kind", 8'(rsp_bus.kind), 8'(want.kind));
            if (rsp_bus.data !== want.data)
               report_mismatch("data", rsp_bus.data, want.data);
            if (rsp_bus.opcode !== want.opcode)
               report_mismatch("opcode", 8'(rsp_bus.opcode), 8'(want.opcode));
            if (rsp_bus.last_of_frame !== want.last)
               report_mismatch("last_of_frame", 8'(rsp_bus.last_of_frame), 8'(want.last));
            words_checked++;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: %0d cycles without a word moving", idle_cycles);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // drives one stream byte and records what it should produce
   task automatic send_octet(input logic [7:0] octet, input logic typed,
                             input deframed_type want);
      deframed_type res;
      while ($urandom_range(99) < gap_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid   = 1'b1;
      req_bus.in_byte = octet;
      do @(posedge clock); while (!req_bus.ready);
      octets_taken++;
      if (deframe_byte(octet, res) || typed)
         pending_words.insert(pending_words.size(), typed ? want : res);
      @(negedge clock);
   endtask

   task automatic send_header(input logic [3:0] opc, input logic masked, input logic [63:0] len);
      send_octet({4'($urandom), opc}, 1'b0, NO_WORD);
      if (len < 64'd126 && $urandom_range(2) != 0) begin
         send_octet({masked, len[6:0]}, 1'b0, NO_WORD);
      end else if (len <= 64'hFFFF && $urandom_range(1) == 0) begin
         send_octet({masked, LEN7_EXT16}, 1'b0, NO_WORD);
         send_octet(len[15:8], 1'b0, NO_WORD);
         send_octet(len[7:0], 1'b0, NO_WORD);
      end else begin
         send_octet({masked, LEN7_EXT64}, 1'b0, NO_WORD);
         for (int i = 7; i >= 0; i--) send_octet(len[i*8 +: 8], 1'b0, NO_WORD);
      end
   endtask

   task automatic send_frame(input logic [3:0] opc, input int len);
      send_header(opc, 1'b1, 64'(len));
      repeat (4) send_octet(8'($urandom), 1'b0, NO_WORD);
      repeat (len) send_octet(8'($urandom), 1'b0, NO_WORD);
   endtask

   task automatic wait_for_results();
      req_bus.valid = 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
   endtask

   task automatic write_max_payload(input logic [15:0] value);
      wait_for_results();
      // the bench idles before the register changes
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_bus.valid       = 1'b1;
      csr_bus.max_payload = value;
      do @(posedge clock); while (!csr_bus.ready);
      p_max = value;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   initial begin : stimulus
      logic [3:0]  opc;
      logic [63:0] big;
      int          lim;
      int          len;
      int          start;
      string       ending;

      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.in_byte     = 8'h00;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.max_payload = 16'h0000;
      p_phase  = PH_HDR0;
      p_opcode = '0;
      p_masked = 1'b0;
      p_length = '0;
      p_left   = '0;
      p_key    = '0;
      p_pos    = '0;
      p_max    = MAX_PAYLOAD_RESET;

      repeat (10) @(negedge clock);
      reset = 1'b0;

      foreach (DIRECTED[i]) send_octet(DIRECTED[i].octet, DIRECTED[i].typed, DIRECTED[i].want);

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            1: write_max_payload(16'd0);
            2: write_max_payload(16'hFFFF);
            3: write_max_payload(16'($urandom_range(1, 40)));
            4: write_max_payload(16'($urandom));
            default: ;
         endcase
         gap_pct   = GAP_PCT[ph % 4];
         stall_pct = STALL_PCT[ph % 4];
         start     = octets_taken;
         while (octets_taken - start < PHASE_OCTETS) begin
            do opc = 4'($urandom); while (opc == OPC_CLOSE);
            lim = (p_max > 16'd80) ? 80 : int'(p_max);
            len = ($urandom_range(15) == 0) ? lim : $urandom_range(0, (lim < 12) ? lim : 12);
            send_frame(opc, len);
            if ($urandom_range(11) == 0) wait_for_results();
         end
      end

      // the block halts for good here, so only one of these fits in a run
      opc = 4'($urandom);
      big = ($urandom_range(1) == 0) ? 64'(p_max) + 64'($urandom_range(1, 4))
                                     : {32'($urandom), 32'($urandom)} | 64'h1_0000;
      case ($urandom_range(3))
         0: begin
            ending = "close frame";
            send_frame(OPC_CLOSE, $urandom_range(0, (p_max < 16'd8) ? int'(p_max) : 8));
         end
         1: begin
            ending = "oversize frame";
            send_header(opc, 1'b1, big);
         end
         2: begin
            ending = "unmasked frame";
            send_header(opc, 1'b0, 64'($urandom_range(0, (p_max < 16'd8) ? int'(p_max) : 8)));
         end
         default: begin
            ending = "frame both oversize and unmasked";
            send_header(opc, 1'b0, big);
         end
      endcase
      repeat (12) send_octet(8'($urandom), 1'b0, NO_WORD);

      wait_for_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (pending_words.size() != 0)
         report_mismatch("result words never delivered", 8'(pending_words.size()), 8'h00);

      $display("covered %0d stream bytes and %0d result words over five max_payload settings",
               octets_taken, words_checked);
      $display("run ended on a %s followed by ignored bytes", ending);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[websocket_frame_deframer.f]
rtl/core/wsdf_pkg.sv
rtl/core/wsdf_if.sv
rtl/core/wsdf_front.sv
rtl/core/wsdf_queue.sv
rtl/core/wsdf_back.sv
rtl/core/websocket_frame_deframer.sv
tb/tb_websocket_frame_deframer.sv
